/* hdl/i2cram_pkg.sv */
package i2cram_pkg;

  localparam int unsigned TicksPerDelay = 1;
  localparam int unsigned DelayW        = 10;

  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned DevW   = 7;
  localparam logic [DevW-1:0] DevAddrReset = 7'd104;

  // register index, taken from the word address
  localparam logic RegDevAddr = 1'b0;

  localparam logic [1:0] ReqWrite   = 2'd0;
  localparam logic [1:0] ReqRandRd  = 2'd1;
  localparam logic [1:0] ReqCurRd   = 2'd2;

  localparam logic [7:0] MsbMask = 8'h80;

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StStart1   = 4'd1;
  localparam logic [3:0] StStart2   = 4'd2;
  localparam logic [3:0] StTxLow    = 4'd3;
  localparam logic [3:0] StTxHigh   = 4'd4;
  localparam logic [3:0] StAckLow   = 4'd5;
  localparam logic [3:0] StAckHigh  = 4'd6;
  localparam logic [3:0] StAckTail  = 4'd7;
  localparam logic [3:0] StRxLow    = 4'd8;
  localparam logic [3:0] StRxHigh   = 4'd9;
  localparam logic [3:0] StNackLow  = 4'd10;
  localparam logic [3:0] StNackHigh = 4'd11;
  localparam logic [3:0] StStop1    = 4'd12;
  localparam logic [3:0] StStop2    = 4'd13;
  localparam logic [3:0] StStop3    = 4'd14;

  typedef struct packed {
    logic       req_valid;
    logic [1:0] req_type;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
    logic [7:0] rdata;
  } res_t;

endpackage

/* hdl/i2cram_cfg.sv */
module i2cram_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cram_pkg::AddrW-1:0]      paddr,
  input  logic [i2cram_pkg::DataW-1:0]      pwdata,
  output logic [i2cram_pkg::DataW-1:0]      prdata,
  output logic                              pready,
  output logic [i2cram_pkg::DevW-1:0]       dev_addr_o
);
  import i2cram_pkg::*;

  logic [DevW-1:0] dev_q, dev_d;
  logic            wr_en;

  // word index is paddr[2]; anything past register 0 is dropped
  assign wr_en = psel && penable && pwrite && (paddr[2] == RegDevAddr);

  always_comb begin
    dev_d = dev_q;
    if (wr_en) begin
      dev_d = pwdata[DevW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= DevAddrReset;
    end else begin
      dev_q <= dev_d;
    end
  end

  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == RegDevAddr) ? {{(DataW-DevW){1'b0}}, dev_q} : '0;
  assign dev_addr_o = dev_q;

endmodule

/* hdl/i2cram_seq.sv */
module i2cram_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  i2cram_pkg::tick_t              tick_i,
  input  logic [i2cram_pkg::DevW-1:0]    dev_addr_i,
  output i2cram_pkg::res_t               res_o
);
  import i2cram_pkg::*;

  logic [5:0]        phase_q, phase_d;
  logic [3:0]        bits_q, bits_d;
  logic [7:0]        shift_q, shift_d;
  logic [1:0]        kind_q, kind_d;
  logic [7:0]        preg_q, preg_d;
  logic [7:0]        pdata_q, pdata_d;
  logic [7:0]        rx_q, rx_d;
  logic              ack_q, ack_d;
  logic [DelayW-1:0] dly_q, dly_d;

  logic       scl, sda, busy, done, nack, finished;
  logic [3:0] step;
  logic [1:0] stage;
  logic [7:0] dev_byte;

  assign dev_byte = {dev_addr_i, 1'b0};

  always_comb begin
    phase_d  = phase_q;
    bits_d   = bits_q;
    shift_d  = shift_q;
    kind_d   = kind_q;
    preg_d   = preg_q;
    pdata_d  = pdata_q;
    rx_d     = rx_q;
    ack_d    = ack_q;
    dly_d    = dly_q;
    scl      = 1'b1;
    sda      = 1'b1;
    busy     = 1'b1;
    done     = 1'b0;
    nack     = 1'b0;
    finished = 1'b0;

    // new request only from idle; type three is dropped
    if (phase_d == {2'b00, StIdle} && tick_i.req_valid && tick_i.req_type <= ReqCurRd) begin
      kind_d  = tick_i.req_type;
      preg_d  = tick_i.reg_addr;
      pdata_d = tick_i.wdata;
      shift_d = dev_byte | {7'd0, (tick_i.req_type == ReqCurRd)};
      bits_d  = '0;
      ack_d   = 1'b0;
      dly_d   = '0;
      phase_d = {2'b00, StStart1};
    end

    step  = phase_d[3:0];
    stage = phase_d[5:4];

    if (phase_d == {2'b00, StIdle}) begin
      busy = 1'b0;
    end else begin
      finished = (dly_d >= DelayW'(TicksPerDelay - 1));
      case (step)
        StStart1:   begin scl = 1'b1; sda = 1'b1; end
        StStart2:   begin scl = 1'b1; sda = 1'b0; end
        StTxLow:    begin scl = 1'b0; sda = |(shift_d & MsbMask); end
        StTxHigh:   begin scl = 1'b1; sda = |(shift_d & MsbMask); end
        StAckLow, StAckTail, StRxLow, StNackLow: begin
          scl = 1'b0; sda = 1'b1;
        end
        StAckHigh, StRxHigh, StNackHigh: begin
          scl = 1'b1; sda = 1'b1;
        end
        StStop1:    begin scl = 1'b0; sda = 1'b0; end
        StStop2:    begin scl = 1'b1; sda = 1'b0; end
        StStop3:    begin scl = 1'b1; sda = 1'b1; end
        default: begin
          scl = 1'b1; sda = 1'b1; busy = 1'b0; finished = 1'b1;
        end
      endcase

      if (!finished) begin
        dly_d = dly_d + 1'b1;
      end else begin
        dly_d = '0;
        case (step)
          StStart1: phase_d = {stage, StStart2};
          StStart2: begin
            bits_d  = '0;
            phase_d = {stage, StTxLow};
          end
          StTxLow:  phase_d = {stage, StTxHigh};
          StTxHigh: begin
            shift_d = {shift_d[6:0], 1'b0};
            bits_d  = bits_d + 1'b1;
            phase_d = {stage, (bits_d >= 4'd8) ? StAckLow : StTxLow};
          end
          StAckLow:  phase_d = {stage, StAckHigh};
          StAckHigh: begin
            ack_d   = ~tick_i.sda_in;
            phase_d = {stage, StAckTail};
          end
          StAckTail: begin
            if (!ack_d) begin
              phase_d = {stage, StStop1};
            end else if (kind_d == ReqWrite) begin
              if (stage == 2'd0) begin
                shift_d = preg_d; bits_d = '0; phase_d = {2'd1, StTxLow};
              end else if (stage == 2'd1) begin
                shift_d = pdata_d; bits_d = '0; phase_d = {2'd2, StTxLow};
              end else begin
                phase_d = {stage, StStop1};
              end
            end else if (kind_d == ReqRandRd) begin
              if (stage == 2'd0) begin
                shift_d = preg_d; bits_d = '0; phase_d = {2'd1, StTxLow};
              end else if (stage == 2'd1) begin
                // repeated start, then address + R
                shift_d = dev_byte | 8'd1;
                phase_d = {2'd2, StStart1};
              end else begin
                shift_d = '0; bits_d = '0; phase_d = {stage, StRxLow};
              end
            end else begin
              shift_d = '0; bits_d = '0; phase_d = {stage, StRxLow};
            end
          end
          StRxLow:  phase_d = {stage, StRxHigh};
          StRxHigh: begin
            shift_d = {shift_d[6:0], tick_i.sda_in};
            bits_d  = bits_d + 1'b1;
            phase_d = {stage, (bits_d >= 4'd8) ? StNackLow : StRxLow};
          end
          StNackLow:  phase_d = {stage, StNackHigh};
          StNackHigh: begin
            rx_d    = shift_d;
            phase_d = {stage, StStop1};
          end
          StStop1: phase_d = {stage, StStop2};
          StStop2: phase_d = {stage, StStop3};
          StStop3: begin
            done = 1'b1;
            nack = ~ack_d;
            if (nack && kind_d != ReqWrite) begin
              rx_d = '0;
            end
            phase_d = {2'b00, StIdle};
          end
          default: phase_d = {2'b00, StIdle};
        endcase
      end
    end

    res_o.scl_out    = scl;
    res_o.sda_out    = sda;
    res_o.busy_res   = busy;
    res_o.done_res   = done;
    res_o.nack_error = nack;
    res_o.rdata      = rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      kind_q  <= '0;
      preg_q  <= '0;
      pdata_q <= '0;
      rx_q    <= '0;
      ack_q   <= 1'b0;
      dly_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      kind_q  <= kind_d;
      preg_q  <= preg_d;
      pdata_q <= pdata_d;
      rx_q    <= rx_d;
      ack_q   <= ack_d;
      dly_q   <= dly_d;
    end
  end

endmodule

/* hdl/i2c_register_access_master.sv */
// I2C register master driven one bus tick per request: each request carries the
// sampled SDA level and optionally a new transaction (register write, random
// read, current-address read), and yields exactly one result with the SCL/SDA
// drive levels, busy, done, NACK flag and last read byte. A request is taken
// every cycle while results are taken; it is captured in an input register, the
// sequencer advances one step and the result lands in the output register (two
// register stages), so throughput is one request per cycle while results are
// taken. The device address register (reset 0x68) sits at APB address 0.
module i2c_register_access_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_valid_i,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    reg_addr_i,
  input  logic [7:0]                    wdata_i,
  input  logic                          sda_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          scl_out_o,
  output logic                          sda_out_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic                          nack_error_o,
  output logic [7:0]                    rdata_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cram_pkg::AddrW-1:0]  paddr,
  input  logic [i2cram_pkg::DataW-1:0]  pwdata,
  output logic [i2cram_pkg::DataW-1:0]  prdata,
  output logic                          pready
);
  import i2cram_pkg::*;

  logic            s1_vld_q, s1_vld_d;
  tick_t           s1_q;
  logic            out_vld_q, out_vld_d;
  res_t            out_q, res;
  logic            adv;
  logic [DevW-1:0] dev_addr;

  i2cram_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .dev_addr_o (dev_addr)
  );

  i2cram_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .tick_i     (s1_q),
    .dev_addr_i (dev_addr),
    .res_o      (res)
  );

  assign adv        = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || adv;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_ready_o) begin
      s1_vld_d = in_valid_i;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q.req_valid <= req_valid_i;
      s1_q.req_type  <= req_type_i;
      s1_q.reg_addr  <= reg_addr_i;
      s1_q.wdata     <= wdata_i;
      s1_q.sda_in    <= sda_in_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign scl_out_o    = out_q.scl_out;
  assign sda_out_o    = out_q.sda_out;
  assign busy_res_o   = out_q.busy_res;
  assign done_res_o   = out_q.done_res;
  assign nack_error_o = out_q.nack_error;
  assign rdata_o      = out_q.rdata;

endmodule

/* hdl/i2cram_checker.sv */
module i2cram_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          req_valid_i,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    reg_addr_i,
  input  logic [7:0]                    wdata_i,
  input  logic                          sda_in_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          scl_out_o,
  input  logic                          sda_out_o,
  input  logic                          busy_res_o,
  input  logic                          done_res_o,
  input  logic                          nack_error_o,
  input  logic [7:0]                    rdata_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cram_pkg::AddrW-1:0]  paddr,
  input  logic [i2cram_pkg::DataW-1:0]  pwdata,
  input  logic [i2cram_pkg::DataW-1:0]  prdata,
  input  logic                          pready
);

  // done only closes a running transaction
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o)
    else $error("done without busy");

  a_nack_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nack_error_o |-> done_res_o)
    else $error("nack outside done");

  // idle bus: both lines released
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> scl_out_o && sda_out_o)
    else $error("line driven while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rdata_o)
      && $stable(busy_res_o) && $stable(scl_out_o) && $stable(sda_out_o))
    else $error("stalled result changed");

endmodule

bind i2c_register_access_master i2cram_checker u_i2cram_checker (.*);
